// ===== src/mpf_pkg.sv =====
// ----------------------------------------------------------------------------
// mpf_pkg
// Types and constants shared by the PUBLISH framer and its port checker.
// ----------------------------------------------------------------------------
package mpf_pkg;

  localparam logic       OP_START = 1'b0;
  localparam logic       OP_BODY  = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_LEN  = 2'd1;
  localparam logic [1:0] STATUS_WILD = 2'd2;

  localparam logic [7:0] FIXED_HDR    = 8'h30;
  localparam logic [7:0] VARINT_CONT  = 8'h80;
  localparam logic [7:0] CHAR_HASH    = 8'h23;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_packet;
    logic [1:0] status;
  } result_t;

endpackage

// ===== src/mqtt_publish_framer.sv =====
// ----------------------------------------------------------------------------
// mqtt_publish_framer
// Builds QoS-0 PUBLISH packets as a byte stream from a start word and body words.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_axis    in         start word (lengths, retain) or one body byte
//  m_axis    out        framed packet byte, or the length error word
//
//  A body word gives at most one byte; a valid start word gives 4 to 6 header
//  bytes, the fixed header byte and then the rest shifted out of a small header register.
//  A rejected start word gives its single error word.
//  A skid register behind the output register lets input continue for one
//  word while the output stalls; input waits while the skid is full or header bytes remain.
//  Synchronous reset clears the counters, flags and all valid bits.
module mqtt_publish_framer #(
  parameter int TOPIC_LIMIT   = 256,
  parameter int PAYLOAD_LIMIT = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // retain[0], topic_length[16:1], payload_length[32:17], data_byte[40:33], zero pad
  input  logic [mpf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // operation[0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_byte[7:0]
  output logic [mpf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // end_of_packet
  output logic                            m_axis_tlast,
  // end_of_run[0], status[2:1]
  output logic [mpf_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

  logic [15:0] topic_left, topic_left_next;
  logic [15:0] payload_left, payload_left_next;
  logic        packet_open, packet_open_next;
  logic        wildcard_seen, wildcard_seen_next;

  logic [7:0]  burst [5];
  logic [7:0]  burst_fill [5];
  logic [2:0]  burst_left;

  mpf_pkg::result_t out_q, skid_q, push_res;
  logic        out_valid, skid_valid;
  logic        push, pop, accept, burst_emit, burst_load;

  logic        in_retain;
  logic [15:0] in_tlen, in_plen;
  logic [7:0]  in_data;
  logic        len_bad, is_wild;
  logic [17:0] rem;
  logic [1:0]  nv;
  logic [6:0]  g0, g1, g2;

  assign in_retain = s_axis_tdata[0];
  assign in_tlen   = s_axis_tdata[16:1];
  assign in_plen   = s_axis_tdata[32:17];
  assign in_data   = s_axis_tdata[40:33];

  assign s_axis_tready = (burst_left == 3'd0) && !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign burst_emit    = (burst_left != 3'd0) && !skid_valid;
  assign pop           = out_valid && m_axis_tready;

  assign len_bad = (in_tlen == 16'd0) || (in_tlen > 16'(TOPIC_LIMIT)) ||
                   (in_plen > 16'(PAYLOAD_LIMIT));
  assign rem     = 18'(in_tlen) + 18'(in_plen) + 18'd2;
  assign g0      = rem[6:0];
  assign g1      = rem[13:7];
  assign g2      = {3'b000, rem[17:14]};
  assign nv      = (rem[17:14] != 4'd0) ? 2'd3 : ((rem[13:7] != 7'd0) ? 2'd2 : 2'd1);
  assign is_wild = (in_data == mpf_pkg::CHAR_HASH) || (in_data == mpf_pkg::CHAR_PLUS);

  always_comb begin
    burst_fill[0] = '0;
    burst_fill[1] = '0;
    burst_fill[2] = '0;
    burst_fill[3] = '0;
    burst_fill[4] = '0;
    case (nv)
      2'd2: begin
        burst_fill[0] = mpf_pkg::VARINT_CONT | {1'b0, g0};
        burst_fill[1] = {1'b0, g1};
        burst_fill[2] = in_tlen[15:8];
        burst_fill[3] = in_tlen[7:0];
      end
      2'd3: begin
        burst_fill[0] = mpf_pkg::VARINT_CONT | {1'b0, g0};
        burst_fill[1] = mpf_pkg::VARINT_CONT | {1'b0, g1};
        burst_fill[2] = {1'b0, g2};
        burst_fill[3] = in_tlen[15:8];
        burst_fill[4] = in_tlen[7:0];
      end
      default: begin
        burst_fill[0] = {1'b0, g0};
        burst_fill[1] = in_tlen[15:8];
        burst_fill[2] = in_tlen[7:0];
      end
    endcase
  end

  always_comb begin
    topic_left_next    = topic_left;
    payload_left_next  = payload_left;
    packet_open_next   = packet_open;
    wildcard_seen_next = wildcard_seen;
    push               = 1'b0;
    push_res           = '0;
    burst_load         = 1'b0;
    if (burst_emit) begin
      push                = 1'b1;
      push_res.out_byte   = burst[0];
      push_res.end_of_run = (burst_left == 3'd1);
      push_res.status     = mpf_pkg::STATUS_OK;
    end else if (accept) begin
      if (s_axis_tuser == mpf_pkg::OP_START) begin
        topic_left_next    = in_tlen;
        payload_left_next  = in_plen;
        wildcard_seen_next = 1'b0;
        push               = 1'b1;
        if (len_bad) begin
          packet_open_next       = 1'b0;
          push_res.out_byte      = '0;
          push_res.end_of_run    = 1'b1;
          push_res.end_of_packet = 1'b1;
          push_res.status        = mpf_pkg::STATUS_LEN;
        end else begin
          packet_open_next  = 1'b1;
          burst_load        = 1'b1;
          push_res.out_byte = mpf_pkg::FIXED_HDR | {7'd0, in_retain};
          push_res.status   = mpf_pkg::STATUS_OK;
        end
      end else if ((topic_left == 16'd0) && (payload_left == 16'd0)) begin
        packet_open_next = 1'b0;
      end else begin
        if (topic_left != 16'd0) begin
          topic_left_next = topic_left - 16'd1;
          if (is_wild) begin
            wildcard_seen_next = 1'b1;
          end
        end else begin
          payload_left_next = payload_left - 16'd1;
        end
        if (packet_open) begin
          push                = 1'b1;
          push_res.out_byte   = in_data;
          push_res.end_of_run = 1'b1;
          if ((topic_left_next == 16'd0) && (payload_left_next == 16'd0)) begin
            push_res.end_of_packet = 1'b1;
            push_res.status = wildcard_seen_next ? mpf_pkg::STATUS_WILD : mpf_pkg::STATUS_OK;
            packet_open_next   = 1'b0;
            wildcard_seen_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      topic_left    <= '0;
      payload_left  <= '0;
      packet_open   <= 1'b0;
      wildcard_seen <= 1'b0;
      burst_left    <= '0;
    end else begin
      topic_left    <= topic_left_next;
      payload_left  <= payload_left_next;
      packet_open   <= packet_open_next;
      wildcard_seen <= wildcard_seen_next;
      if (burst_load) begin
        burst_left <= 3'(nv) + 3'd2;
      end else if (burst_emit) begin
        burst_left <= burst_left - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst_load) begin
      for (int i = 0; i < 5; i++) begin
        burst[i] <= burst_fill[i];
      end
    end else if (burst_emit) begin
      for (int i = 0; i < 4; i++) begin
        burst[i] <= burst[i+1];
      end
      burst[4] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push && pop) begin
        if (skid_valid) begin
          out_q  <= skid_q;
          skid_q <= push_res;
        end else begin
          out_q <= push_res;
        end
      end else if (push) begin
        if (out_valid) begin
          skid_q     <= push_res;
          skid_valid <= 1'b1;
        end else begin
          out_q     <= push_res;
          out_valid <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid) begin
          out_q      <= skid_q;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_q.out_byte;
  assign m_axis_tlast  = out_q.end_of_packet;
  assign m_axis_tuser  = {out_q.status, out_q.end_of_run};

endmodule

// ===== src/mpf_checker.sv =====
// ----------------------------------------------------------------------------
// mpf_checker
// Port-level checks on the framer's output stream, bound to every framer instance.
// ----------------------------------------------------------------------------
module mpf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mpf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic [mpf_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser[2:1] == mpf_pkg::STATUS_LEN)) |->
      (m_axis_tlast && m_axis_tuser[0] && (m_axis_tdata == '0)))
    else $error("length error word is malformed");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0])
    else $error("packet end without end of run");

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser[2:1] != mpf_pkg::STATUS_OK)) |-> m_axis_tlast)
    else $error("status set on a word that does not end the packet");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[2:1] != 2'd3))
    else $error("undefined status code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("stalled output word changed");

endmodule

bind mqtt_publish_framer mpf_checker u_mpf_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
